// ===== sv/wdw_pkg.sv =====
// Package for the worker deadline watchdog: field widths and event codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wdw_pkg;

	localparam int TIME_BITS   = 64;
	localparam int COUNT_BITS  = 32;
	localparam int WORKER_BITS = 3;

	typedef enum logic [1:0] {
		OP_ARM       = 2'd0,
		OP_HEARTBEAT = 2'd1,
		OP_DISARM    = 2'd2,
		OP_EVALUATE  = 2'd3
	} op_t;

	typedef logic [TIME_BITS-1:0]   time_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [WORKER_BITS-1:0] worker_t;

endpackage

`default_nettype wire

// ===== sv/worker_deadline_watchdog_core.sv =====
// Worker deadline watchdog core: input register, event logic, status register.
// Depends on wdw_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Supervises one worker at a time through arm, heartbeat, disarm and evaluate
// events. Every accepted event yields exactly one status transaction showing
// the state after that event. One event is accepted per clock cycle while the
// output is not stalled; events pass the input register, then the status
// register. The 64-bit subtract and compares of the event time against the
// stored heartbeat time are done between the two registers.
module worker_deadline_watchdog_core (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [1:0]               op,
	input  wire  wdw_pkg::worker_t   worker,
	input  wire  wdw_pkg::time_t     now_us,
	input  wire  wdw_pkg::time_t     deadline_us,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic                     accepted,
	output logic                     is_armed,
	output logic                     has_expired,
	output wdw_pkg::worker_t         active_worker,
	output wdw_pkg::worker_t         tripped_worker,
	output wdw_pkg::time_t           observed_age,
	output wdw_pkg::count_t          arms_total,
	output wdw_pkg::count_t          beats_total,
	output wdw_pkg::count_t          trips_total
);
	import wdw_pkg::*;

	// input stage
	logic    valid_s1;
	op_t     op_s1;
	worker_t worker_s1;
	time_t   now_s1;
	time_t   gap_s1;

	// watchdog state
	logic    armed_q;
	logic    expired_q;
	worker_t worker_q;
	worker_t tripped_q;
	time_t   last_beat_q;
	time_t   allowed_gap_q;
	time_t   age_q;
	count_t  arm_cnt_q;
	count_t  beat_cnt_q;
	count_t  trip_cnt_q;

	// result register
	logic    out_valid_q;
	logic    ok_q;

	logic    advance;
	logic    take_in;

	logic    nxt_ok;
	logic    nxt_armed;
	logic    nxt_expired;
	worker_t nxt_worker;
	worker_t nxt_tripped;
	time_t   nxt_last_beat;
	time_t   nxt_gap;
	time_t   nxt_age;
	count_t  nxt_arm_cnt;
	count_t  nxt_beat_cnt;
	count_t  nxt_trip_cnt;
	time_t   age_calc;
	logic    time_back;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1     <= op_t'(op);
			worker_s1 <= worker;
			now_s1    <= now_us;
			gap_s1    <= deadline_us;
		end
	end

	assign time_back = now_s1 < last_beat_q;
	assign age_calc  = time_back ? allowed_gap_q : (now_s1 - last_beat_q);

	always_comb begin
		nxt_ok        = 1'b0;
		nxt_armed     = armed_q;
		nxt_expired   = expired_q;
		nxt_worker    = worker_q;
		nxt_tripped   = tripped_q;
		nxt_last_beat = last_beat_q;
		nxt_gap       = allowed_gap_q;
		nxt_age       = age_q;
		nxt_arm_cnt   = arm_cnt_q;
		nxt_beat_cnt  = beat_cnt_q;
		nxt_trip_cnt  = trip_cnt_q;
		case (op_s1)
			OP_ARM: begin
				if (!armed_q && worker_s1 != '0 && now_s1 != '0 && gap_s1 != '0) begin
					nxt_worker    = worker_s1;
					nxt_armed     = 1'b1;
					nxt_expired   = 1'b0;
					nxt_last_beat = now_s1;
					nxt_gap       = gap_s1;
					nxt_age       = '0;
					nxt_arm_cnt   = arm_cnt_q + count_t'(1);
					nxt_beat_cnt  = beat_cnt_q + count_t'(1);
					nxt_ok        = 1'b1;
				end
			end
			OP_HEARTBEAT: begin
				if (armed_q && !expired_q && worker_s1 == worker_q && now_s1 != '0
						&& !time_back) begin
					nxt_last_beat = now_s1;
					nxt_age       = '0;
					nxt_beat_cnt  = beat_cnt_q + count_t'(1);
					nxt_ok        = 1'b1;
				end
			end
			OP_DISARM: begin
				if (armed_q && worker_s1 == worker_q) begin
					nxt_worker = '0;
					nxt_armed  = 1'b0;
					nxt_ok     = 1'b1;
				end
			end
			OP_EVALUATE: begin
				if (armed_q && !expired_q) begin
					nxt_age = age_calc;
					if (age_calc >= allowed_gap_q) begin
						nxt_expired  = 1'b1;
						nxt_tripped  = worker_q;
						nxt_trip_cnt = trip_cnt_q + count_t'(1);
						nxt_ok       = 1'b1;
					end
				end
			end
			default: begin
				nxt_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			expired_q     <= 1'b0;
			worker_q      <= '0;
			tripped_q     <= '0;
			last_beat_q   <= '0;
			allowed_gap_q <= '0;
			age_q         <= '0;
			arm_cnt_q     <= '0;
			beat_cnt_q    <= '0;
			trip_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			ok_q          <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				armed_q       <= nxt_armed;
				expired_q     <= nxt_expired;
				worker_q      <= nxt_worker;
				tripped_q     <= nxt_tripped;
				last_beat_q   <= nxt_last_beat;
				allowed_gap_q <= nxt_gap;
				age_q         <= nxt_age;
				arm_cnt_q     <= nxt_arm_cnt;
				beat_cnt_q    <= nxt_beat_cnt;
				trip_cnt_q    <= nxt_trip_cnt;
				ok_q          <= nxt_ok;
			end
		end
	end

	// status held in the state registers themselves
	assign out_valid      = out_valid_q;
	assign accepted       = ok_q;
	assign is_armed       = armed_q;
	assign has_expired    = expired_q;
	assign active_worker  = worker_q;
	assign tripped_worker = tripped_q;
	assign observed_age   = age_q;
	assign arms_total     = arm_cnt_q;
	assign beats_total    = beat_cnt_q;
	assign trips_total    = trip_cnt_q;

	a_armed_has_worker: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q == (worker_q != '0))
		else $error("armed flag and active worker disagree");

	a_trip_counts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(expired_q) |-> trip_cnt_q == $past(trip_cnt_q) + count_t'(1))
		else $error("expiry without trip count");

	a_trip_while_armed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(expired_q) |-> armed_q)
		else $error("expiry while not armed");

	a_arm_counts_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(arm_cnt_q != $past(arm_cnt_q)) |-> (beat_cnt_q != $past(beat_cnt_q)))
		else $error("arm without heartbeat count");

	a_state_needs_transaction: assert property (@(posedge clk) disable iff (!arst_n)
		(trip_cnt_q != $past(trip_cnt_q)) |-> out_valid_q)
		else $error("state changed without a result transaction");

endmodule

`default_nettype wire
